>>> sv/dfr_pkg.sv
package dfr_pkg;

	localparam int FIXED_FRAME_LEN = 32;
	localparam int MAX_FRAME_LEN   = 255;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_GUARD_MS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VAR_HDR     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FIXED_HDR   = 2'd3;

	localparam logic [15:0] GUARD_MS_RST    = 16'd20;
	localparam logic [7:0]  MAX_PAYLOAD_RST = 8'd251;
	localparam logic [7:0]  VAR_HDR_RST     = 8'hAA;
	localparam logic [7:0]  FIXED_HDR_RST   = 8'hFF;

	localparam logic [2:0] EV_NONE      = 3'd0;
	localparam logic [2:0] EV_FIXED_OK  = 3'd1;
	localparam logic [2:0] EV_FIXED_BAD = 3'd2;
	localparam logic [2:0] EV_VAR_OK    = 3'd3;
	localparam logic [2:0] EV_VAR_BAD   = 3'd4;

	localparam logic [1:0] FT_NONE  = 2'd0;
	localparam logic [1:0] FT_FIXED = 2'd1;
	localparam logic [1:0] FT_VAR   = 2'd2;

	typedef struct packed {
		logic [15:0] guard_ms;
		logic [7:0]  max_payload_len;
		logic [7:0]  var_header_byte;
		logic [7:0]  fixed_header_byte;
	} cfg_t;

	typedef struct packed {
		logic [1:0] frame_type;
		logic [7:0] position;
		logic [7:0] data_out;
		logic [2:0] event_res;
	} res_t;

	// data bits enter at bit 0, poly applied when bit 15 falls out
	function automatic logic [15:0] crc_shift_in(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        top;
		c = crc;
		for (int k = 7; k >= 0; k--) begin
			top = c[15];
			c = {c[14:0], b[k]};
			if (top) c = c ^ CRC_POLY;
		end
		return c;
	endfunction

	function automatic logic [15:0] crc_ccitt(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
			else c = {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

>>> sv/dfr_parser.sv
module dfr_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,
	input  logic [7:0]        data_in,
	input  logic [31:0]       now_ms,
	input  dfr_pkg::cfg_t     cfg,
	output dfr_pkg::res_t     res
);

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_FIXED,
		MODE_VLEN,
		MODE_VBODY
	} mode_t;

	localparam logic [8:0] FIXED_CRC_POS = 9'(dfr_pkg::FIXED_FRAME_LEN - 2);
	localparam logic [8:0] MAX_FRAME     = 9'(dfr_pkg::MAX_FRAME_LEN);

	mode_t       mode_q, mode_n, mode_e;
	logic [7:0]  count_q, count_n, count_e;
	logic [7:0]  len_q, len_n, len_e;
	logic [15:0] crc_q, crc_n;
	logic [7:0]  crc_low_q, crc_low_n;
	logic [31:0] last_q;
	logic [31:0] delta;
	logic        timeout;
	logic        bad_len;
	logic [8:0]  pos9;
	logic [8:0]  var_crc_pos;

	always_comb begin
		delta   = now_ms - last_q;
		timeout = (mode_q != MODE_IDLE) && (delta > {16'b0, cfg.guard_ms});
		mode_e  = timeout ? MODE_IDLE : mode_q;
		count_e = timeout ? 8'd0 : count_q;
		len_e   = timeout ? 8'd0 : len_q;

		mode_n    = mode_e;
		count_n   = count_e;
		len_n     = len_e;
		crc_n     = crc_q;
		crc_low_n = crc_low_q;

		pos9        = {1'b0, count_e};
		var_crc_pos = {1'b0, len_e} + 9'd2;
		bad_len     = (data_in < 8'd2)
			|| ({1'b0, data_in} > ({1'b0, cfg.max_payload_len} + 9'd2))
			|| (({1'b0, data_in} + 9'd4) > MAX_FRAME);

		res            = '0;
		res.data_out   = data_in;

		case (mode_e)
			MODE_IDLE: begin
				if (data_in == cfg.fixed_header_byte) begin
					mode_n         = MODE_FIXED;
					count_n        = 8'd1;
					crc_n          = dfr_pkg::crc_shift_in(dfr_pkg::CRC_INIT, data_in);
					res.frame_type = dfr_pkg::FT_FIXED;
				end else if (data_in == cfg.var_header_byte) begin
					mode_n         = MODE_VLEN;
					count_n        = 8'd1;
					crc_n          = dfr_pkg::crc_ccitt(dfr_pkg::CRC_INIT, data_in);
					res.frame_type = dfr_pkg::FT_VAR;
				end
			end
			MODE_FIXED: begin
				res.position   = count_e;
				res.frame_type = dfr_pkg::FT_FIXED;
				if (pos9 < FIXED_CRC_POS) begin
					crc_n   = dfr_pkg::crc_shift_in(crc_q, data_in);
					count_n = count_e + 8'd1;
				end else if (pos9 == FIXED_CRC_POS) begin
					crc_low_n = data_in;
					count_n   = count_e + 8'd1;
				end else begin
					res.event_res = ({data_in, crc_low_q} == crc_q) ?
						dfr_pkg::EV_FIXED_OK : dfr_pkg::EV_FIXED_BAD;
					mode_n  = MODE_IDLE;
					count_n = 8'd0;
				end
			end
			MODE_VLEN: begin
				len_n = data_in;
				if (bad_len) begin
					// drop silently, byte reported as outside any frame
					mode_n  = MODE_IDLE;
					count_n = 8'd0;
				end else begin
					crc_n          = dfr_pkg::crc_ccitt(crc_q, data_in);
					mode_n         = MODE_VBODY;
					count_n        = 8'd2;
					res.position   = 8'd1;
					res.frame_type = dfr_pkg::FT_VAR;
				end
			end
			MODE_VBODY: begin
				res.position   = count_e;
				res.frame_type = dfr_pkg::FT_VAR;
				if (pos9 < var_crc_pos) begin
					crc_n   = dfr_pkg::crc_ccitt(crc_q, data_in);
					count_n = count_e + 8'd1;
				end else if (pos9 == var_crc_pos) begin
					crc_low_n = data_in;
					count_n   = count_e + 8'd1;
				end else begin
					res.event_res = ({data_in, crc_low_q} == crc_q) ?
						dfr_pkg::EV_VAR_OK : dfr_pkg::EV_VAR_BAD;
					mode_n  = MODE_IDLE;
					count_n = 8'd0;
				end
			end
			default: begin
				mode_n  = MODE_IDLE;
				count_n = 8'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			count_q   <= 8'd0;
			len_q     <= 8'd0;
			crc_q     <= dfr_pkg::CRC_INIT;
			crc_low_q <= 8'd0;
			last_q    <= 32'd0;
		end else if (acc) begin
			mode_q    <= mode_n;
			count_q   <= count_n;
			len_q     <= len_n;
			crc_q     <= crc_n;
			crc_low_q <= crc_low_n;
			last_q    <= now_ms;
		end
	end

endmodule

>>> sv/dfr_skid.sv
module dfr_skid (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  dfr_pkg::res_t in_res,
	output logic          out_valid,
	input  logic          out_ready,
	output dfr_pkg::res_t out_res
);

	logic          out_valid_q;
	logic          skid_valid_q;
	dfr_pkg::res_t out_q;
	dfr_pkg::res_t skid_q;

	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid && !skid_valid_q) begin
			// output stalled: park the new item
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : in_res;
		end else if (in_valid && !skid_valid_q) begin
			skid_q <= in_res;
		end
	end

endmodule

>>> sv/dual_frame_receiver_crc16.sv
// Serial frame receiver: each input item is one received byte with its
// millisecond arrival time, and each item yields exactly one result item that
// echoes the byte with its frame kind, its position in the frame and, on the
// last byte of a frame, the CRC verdict. Fixed frames open with the fixed
// header byte and are 32 bytes long; variable frames open with the variable
// header byte, a length byte and the body, and end with a low-first CRC-16.
// One item is taken per clock while s_tready is high: the frame state and the
// byte-wide CRC update sit in one parse stage, and the result is registered
// into the output or skid register. A two-entry output buffer keeps taking
// items while a result waits; s_tready drops only once both entries are full.
// A gap longer than guard_ms between bytes abandons a partial frame.
// Configuration writes are always accepted and take effect on the next byte.
module dual_frame_receiver_crc16 (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [39:0]                      s_tdata,  // data_in[7:0], now_ms[39:8]
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [23:0]                      m_tdata,  // event_res[2:0], data_out[10:3],
	                                                   // position[18:11], zero[23:19]
	output logic [1:0]                       m_tuser,  // frame_type[1:0]
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [dfr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dfr_pkg::CFG_DATA_W-1:0]   cfg_data
);

	dfr_pkg::cfg_t cfg_q;
	dfr_pkg::res_t res;
	dfr_pkg::res_t out_res;
	logic          acc;

	assign cfg_ready = 1'b1;
	assign acc       = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.guard_ms          <= dfr_pkg::GUARD_MS_RST;
			cfg_q.max_payload_len   <= dfr_pkg::MAX_PAYLOAD_RST;
			cfg_q.var_header_byte   <= dfr_pkg::VAR_HDR_RST;
			cfg_q.fixed_header_byte <= dfr_pkg::FIXED_HDR_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				dfr_pkg::REG_GUARD_MS:    cfg_q.guard_ms          <= cfg_data;
				dfr_pkg::REG_MAX_PAYLOAD: cfg_q.max_payload_len   <= cfg_data[7:0];
				dfr_pkg::REG_VAR_HDR:     cfg_q.var_header_byte   <= cfg_data[7:0];
				dfr_pkg::REG_FIXED_HDR:   cfg_q.fixed_header_byte <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	dfr_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.data_in (s_tdata[7:0]),
		.now_ms  (s_tdata[39:8]),
		.cfg     (cfg_q),
		.res     (res)
	);

	dfr_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_res    (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {5'b0, out_res.position, out_res.data_out, out_res.event_res};
	assign m_tuser = out_res.frame_type;

	// a byte outside any frame carries neither a verdict nor a position
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == dfr_pkg::FT_NONE) |-> (m_tdata[18:0] & 19'h7F807) == 19'd0)
		else $error("unframed byte with event or position");

	// fixed-frame verdict codes appear only on fixed-frame bytes
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] == dfr_pkg::EV_FIXED_OK || m_tdata[2:0] == dfr_pkg::EV_FIXED_BAD)
		|-> m_tuser == dfr_pkg::FT_FIXED)
		else $error("fixed verdict on non-fixed byte");

	// input stalls only with a result pending on the output
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with empty output");

endmodule

>>> tb/frame_result_checker.sv
module frame_result_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [39:0]                    s_tdata,  // data_in[7:0], now_ms[39:8]
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [23:0]                    m_tdata,  // event_res[2:0], data_out[10:3],
	                                                 // position[18:11], zero[23:19]
	input  logic [1:0]                     m_tuser,  // frame_type[1:0]
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [dfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dfr_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             mismatches,
	output int                             pending,
	output logic [15:0]                    frame_crc
);
	timeunit 1ns;
	timeprecision 1ps;

	import dfr_pkg::*;

	typedef enum logic [1:0] {
		PARSE_IDLE,
		PARSE_FIXED,
		PARSE_LEN,
		PARSE_BODY
	} parse_t;

	cfg_t        regs;
	parse_t      mode;
	logic [7:0]  count;
	logic [7:0]  body_len;
	logic [7:0]  crc_low;
	logic [15:0] crc_acc;
	logic [31:0] last_stamp;
	res_t        expected_q[$];
	res_t        want;

	// the stimulus closes its frames with this running value
	assign frame_crc = crc_acc;

	// fixed frames: the byte is pushed in at the low end, msb first
	function automatic logic [15:0] shift_in_crc(input logic [15:0] acc, input logic [7:0] d);
		logic msb;
		for (int i = 7; i >= 0; i--) begin
			msb = acc[15];
			acc = {acc[14:0], d[i]} ^ (msb ? CRC_POLY : 16'h0000);
		end
		return acc;
	endfunction

	function automatic logic [15:0] ccitt_crc(input logic [15:0] acc, input logic [7:0] d);
		acc = acc ^ {d, 8'h00};
		repeat (8)
			acc = acc[15] ? ({acc[14:0], 1'b0} ^ CRC_POLY) : {acc[14:0], 1'b0};
		return acc;
	endfunction

	function automatic res_t predict_byte(input logic [7:0] d, input logic [31:0] stamp);
		res_t        r;
		logic [15:0] got;
		int          total;
		r = '0;
		r.data_out = d;
		// drop a partial frame after a long gap, then treat the byte as idle
		if (mode != PARSE_IDLE && (stamp - last_stamp) > {16'h0000, regs.guard_ms}) begin
			mode = PARSE_IDLE;
			count = '0;
		end
		last_stamp = stamp;
		got = {d, crc_low};
		total = int'(body_len) + 4;
		case (mode)
			PARSE_IDLE: begin
				if (d == regs.fixed_header_byte) begin
					mode = PARSE_FIXED;
					count = 8'd1;
					crc_acc = shift_in_crc(CRC_INIT, d);
					r.frame_type = FT_FIXED;
				end else if (d == regs.var_header_byte) begin
					mode = PARSE_LEN;
					count = 8'd1;
					crc_acc = ccitt_crc(CRC_INIT, d);
					r.frame_type = FT_VAR;
				end
			end
			PARSE_FIXED: begin
				r.position = count;
				r.frame_type = FT_FIXED;
				if (int'(count) < FIXED_FRAME_LEN - 2) begin
					crc_acc = shift_in_crc(crc_acc, d);
					count = count + 8'd1;
				end else if (int'(count) == FIXED_FRAME_LEN - 2) begin
					crc_low = d;
					count = count + 8'd1;
				end else begin
					r.event_res = (got == crc_acc) ? EV_FIXED_OK : EV_FIXED_BAD;
					mode = PARSE_IDLE;
					count = '0;
				end
			end
			PARSE_LEN: begin
				body_len = d;
				if (d < 8'd2 || int'(d) > int'(regs.max_payload_len) + 2 ||
						int'(d) + 4 > MAX_FRAME_LEN) begin
					mode = PARSE_IDLE;
					count = '0;
				end else begin
					crc_acc = ccitt_crc(crc_acc, d);
					mode = PARSE_BODY;
					count = 8'd2;
					r.position = 8'd1;
					r.frame_type = FT_VAR;
				end
			end
			default: begin
				r.position = count;
				r.frame_type = FT_VAR;
				if (int'(count) < total - 2) begin
					crc_acc = ccitt_crc(crc_acc, d);
					count = count + 8'd1;
				end else if (int'(count) == total - 2) begin
					crc_low = d;
					count = count + 8'd1;
				end else begin
					r.event_res = (got == crc_acc) ? EV_VAR_OK : EV_VAR_BAD;
					mode = PARSE_IDLE;
					count = '0;
				end
			end
		endcase
		return r;
	endfunction

	function automatic void check_field(input string what, input logic [7:0] exp_val,
			input logic [7:0] got_val);
		if (exp_val !== got_val) begin
			$display("%0t: %s expected %0d got %0d", $time, what, exp_val, got_val);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.guard_ms = GUARD_MS_RST;
			regs.max_payload_len = MAX_PAYLOAD_RST;
			regs.var_header_byte = VAR_HDR_RST;
			regs.fixed_header_byte = FIXED_HDR_RST;
			mode = PARSE_IDLE;
			count = '0;
			body_len = '0;
			crc_low = '0;
			crc_acc = CRC_INIT;
			last_stamp = '0;
			expected_q.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: no item expected, got tdata %h tuser %h",
						$time, m_tdata, m_tuser);
					mismatches++;
				end else begin
					want = expected_q.pop_front();
					check_field("event_res", want.event_res, m_tdata[2:0]);
					check_field("data_out", want.data_out, m_tdata[10:3]);
					check_field("position", want.position, m_tdata[18:11]);
					check_field("frame_type", want.frame_type, m_tuser);
				end
			end
			if (s_tvalid && s_tready)
				expected_q.push_back(predict_byte(s_tdata[7:0], s_tdata[39:8]));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_GUARD_MS:    regs.guard_ms = cfg_data;
					REG_MAX_PAYLOAD: regs.max_payload_len = cfg_data[7:0];
					REG_VAR_HDR:     regs.var_header_byte = cfg_data[7:0];
					REG_FIXED_HDR:   regs.fixed_header_byte = cfg_data[7:0];
					default: ;
				endcase
			end
			pending = expected_q.size();
		end
	end

endmodule

>>> tb/dual_frame_receiver_crc16_tb.sv
module dual_frame_receiver_crc16_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dfr_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;

	typedef enum {
		FRAME_GOOD,
		FRAME_BAD_CRC,
		FRAME_BAD_LEN
	} frame_kind_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [39:0]           s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [23:0]           m_tdata;
	logic [1:0]            m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    pending;
	logic [15:0]           frame_crc;

	int          send_idle;
	int          recv_idle;
	bit          hold_request;
	bit          need_gap;
	int          sent;
	int          cycles = 0;
	logic [31:0] stamp;
	logic [15:0] guard_cur;
	logic [7:0]  max_cur;
	logic [7:0]  var_hdr_cur;
	logic [7:0]  fixed_hdr_cur;

	always #10 clk = ~clk;

	dual_frame_receiver_crc16 dut (.*);

	frame_result_checker results_chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("dual_frame_receiver_crc16_tb: errors");
			$finish;
		end
	end

	// result side: random stalls, or one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	function automatic logic [31:0] next_delta();
		int          pick;
		logic [31:0] g;
		g = {16'h0000, guard_cur};
		if (need_gap) begin
			need_gap = 1'b0;
			return g + 32'd1 + $urandom_range(0, 1000);
		end
		pick = $urandom_range(999);
		if (pick < 5)
			return g + 32'd1;
		if (pick < 10)
			return $urandom;
		if (pick < 30)
			return g;
		return $urandom_range(0, g);
	endfunction

	// called and returns at a falling edge; valid stays up for the next item
	task automatic put_byte(input logic [7:0] b, input logic [31:0] delta);
		stamp = stamp + delta;
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {stamp, b};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic set_config(input logic [15:0] g, input logic [7:0] mp, input logic [7:0] vh,
			input logic [7:0] fh);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		write_reg(REG_GUARD_MS, g);
		write_reg(REG_MAX_PAYLOAD, {8'h00, mp});
		write_reg(REG_VAR_HDR, {8'h00, vh});
		write_reg(REG_FIXED_HDR, {8'h00, fh});
		cfg_valid <= 1'b0;
		guard_cur = g;
		max_cur = mp;
		var_hdr_cur = vh;
		fixed_hdr_cur = fh;
	endtask

	// finish a frame with the running CRC, optionally spoiled in one byte
	task automatic close_frame(input bit corrupt);
		logic [15:0] c;
		c = frame_crc;
		if (corrupt) begin
			if ($urandom_range(1))
				c[7:0] = c[7:0] ^ 8'($urandom_range(1, 255));
			else
				c[15:8] = c[15:8] ^ 8'($urandom_range(1, 255));
		end
		put_byte(c[7:0], next_delta());
		put_byte(c[15:8], next_delta());
	endtask

	task automatic send_fixed(input bit good);
		put_byte(fixed_hdr_cur, next_delta());
		repeat (FIXED_FRAME_LEN - 3) put_byte(8'($urandom_range(255)), next_delta());
		close_frame(!good);
	endtask

	task automatic send_var(input frame_kind_t kind);
		int top_len;
		int len;
		top_len = (int'(max_cur) + 2 > 251) ? 251 : int'(max_cur) + 2;
		put_byte(var_hdr_cur, next_delta());
		if (kind == FRAME_BAD_LEN) begin
			if ($urandom_range(1))
				put_byte(8'($urandom_range(0, 1)), next_delta());
			else
				put_byte(8'($urandom_range(top_len + 1, 255)), next_delta());
		end else begin
			if ($urandom_range(9) != 0)
				len = $urandom_range(2, (top_len < 12) ? top_len : 12);
			else
				len = $urandom_range(2, top_len);
			put_byte(len[7:0], next_delta());
			repeat (len) put_byte(8'($urandom_range(255)), next_delta());
			close_frame(kind == FRAME_BAD_CRC);
		end
	endtask

	// open a frame, break it off, and let the next byte come after a timeout
	task automatic send_broken();
		put_byte($urandom_range(1) ? fixed_hdr_cur : var_hdr_cur, next_delta());
		repeat ($urandom_range(0, 6)) put_byte(8'($urandom_range(255)), next_delta());
		need_gap = 1'b1;
	endtask

	task automatic send_noise();
		logic [7:0] b;
		repeat ($urandom_range(1, 4)) begin
			do b = 8'($urandom_range(255)); while (b == var_hdr_cur || b == fixed_hdr_cur);
			put_byte(b, next_delta());
		end
	endtask

	task automatic run_segment(input int count);
		int target;
		int pick;
		target = sent + count;
		stamp = $urandom;
		need_gap = 1'b1;
		while (sent < target) begin
			pick = $urandom_range(99);
			if (pick < 35) begin
				send_fixed($urandom_range(4) != 0);
			end else if (pick < 75) begin
				pick = $urandom_range(9);
				if (pick == 0)
					send_var(FRAME_BAD_LEN);
				else if (pick < 3)
					send_var(FRAME_BAD_CRC);
				else
					send_var(FRAME_GOOD);
			end else if (pick < 88) begin
				send_broken();
			end else begin
				send_noise();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_request = 1'b0;
		need_gap = 1'b0;
		sent = 0;
		send_idle = 12;
		recv_idle = 67;
		stamp = 32'hFFFF_FFF0;
		guard_cur = GUARD_MS_RST;
		max_cur = MAX_PAYLOAD_RST;
		var_hdr_cur = VAR_HDR_RST;
		fixed_hdr_cur = FIXED_HDR_RST;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// stray byte, then shortest variable frames across the timestamp wrap
		put_byte(8'h00, 32'd2);
		put_byte(var_hdr_cur, 32'd2);
		put_byte(8'd2, 32'd2);
		put_byte(8'h00, 32'd2);
		put_byte(8'hFF, 32'd2);
		close_frame(1'b0);
		put_byte(var_hdr_cur, 32'd2);
		put_byte(8'd2, 32'd2);
		put_byte(8'h5A, 32'd2);
		put_byte(8'hA5, 32'd2);
		close_frame(1'b1);
		// length bytes rejected: too short, and past the frame size limit
		put_byte(var_hdr_cur, 32'd2);
		put_byte(8'd0, 32'd2);
		put_byte(var_hdr_cur, 32'd2);
		put_byte(8'd1, 32'd2);
		put_byte(var_hdr_cur, 32'd2);
		put_byte(8'd252, 32'd2);
		// a gap of exactly guard keeps the frame, one more drops it
		put_byte(var_hdr_cur, 32'd2);
		put_byte(8'd3, 32'd2);
		put_byte(8'h10, {16'h0000, guard_cur});
		put_byte(8'h20, {16'h0000, guard_cur} + 32'd1);

		set_config(16'd20, 8'd251, 8'hAA, 8'hFF);
		run_segment(120);
		set_config(16'd0, 8'd0, 8'h00, 8'h80);
		run_segment(120);

		send_idle = 67;
		recv_idle = 12;
		// equal headers: fixed frames take precedence
		set_config(16'hFFFF, 8'd251, 8'hFF, 8'hFF);
		run_segment(120);
		set_config(16'd100, 8'd12, 8'($urandom_range(255)), 8'($urandom_range(255)));
		run_segment(120);

		send_idle = 0;
		recv_idle = 0;
		set_config(16'd5, 8'd251, 8'h01, 8'hFE);
		hold_request = 1'b1;
		run_segment(120);
		set_config(16'($urandom_range(1, 60)), 8'($urandom_range(0, 251)), 8'h7F, 8'h00);
		run_segment(120);

		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("dual_frame_receiver_crc16_tb: clean");
		else
			$display("dual_frame_receiver_crc16_tb: errors");
		$finish;
	end

endmodule
